// File: rtl/core/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

    localparam int unsigned MAX_RES = 4;
    localparam int unsigned RAW_MAX = 3;

    localparam logic [7:0] LINE_LENGTH_RST = 8'd72;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [1:0] PH_ZERO = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    localparam logic [6:0] CHAR_PAD = 7'h3d;
    localparam logic [6:0] CHAR_NL  = 7'h0a;

    // Characters produced by one input item, emitted in order.
    typedef struct packed {
        logic [MAX_RES-1:0][6:0] chars;
        logic [2:0]              count;
    } t_group;

    function automatic logic [6:0] b64_char(input logic [5:0] idx);
        logic [6:0] r;
        r = 7'h2f;
        if (idx < 6'd26) begin
            r = 7'h41 + {1'b0, idx};
        end else if (idx < 6'd52) begin
            r = 7'h61 + {1'b0, idx - 6'd26};
        end else if (idx < 6'd62) begin
            r = 7'h30 + {1'b0, idx - 6'd52};
        end else if (idx == 6'd62) begin
            r = 7'h2b;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/b64e_if.sv
`default_nettype none
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       is_last;

    modport source (output valid, output out_char, output is_last, input ready);
    modport sink   (input valid, input out_char, input is_last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/b64e_encode.sv
`default_nettype none
module b64e_encode
    import b64e_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    b64e_in_if.sink     i_in,
    output t_group      o_grp,
    output logic        o_grp_valid,
    input  wire logic   i_grp_ready
);

    logic       r_in_valid;
    logic       r_cmd;
    logic [7:0] r_byte;
    logic [1:0] r_phase;
    logic [7:0] r_prev;
    logic [7:0] r_col;
    logic [7:0] r_line_len;

    logic       n_take;
    logic [1:0] n_phase;
    logic [7:0] n_col;

    assign n_take      = r_in_valid && i_grp_ready;
    assign o_grp_valid = r_in_valid;
    assign i_in.ready  = !r_in_valid || n_take;

    always_comb begin
        logic [RAW_MAX-1:0][6:0] raw;
        logic [1:0]              raw_cnt;
        logic [1:0]              ph;
        logic [7:0]              col;
        logic [2:0]              cnt;
        raw     = '0;
        raw_cnt = 2'd0;
        n_phase = PH_ZERO;
        ph      = r_phase;
        if (ph == 2'd3) begin
            ph = PH_ZERO;
        end
        if (r_cmd == CMD_DATA) begin
            case (ph)
                PH_ONE: begin
                    raw[0]  = b64_char({r_prev[1:0], r_byte[7:4]});
                    raw_cnt = 2'd1;
                    n_phase = PH_TWO;
                end
                PH_TWO: begin
                    raw[0]  = b64_char({r_prev[3:0], r_byte[7:6]});
                    raw[1]  = b64_char(r_byte[5:0]);
                    raw_cnt = 2'd2;
                    n_phase = PH_ZERO;
                end
                default: begin
                    raw[0]  = b64_char(r_byte[7:2]);
                    raw_cnt = 2'd1;
                    n_phase = PH_ONE;
                end
            endcase
        end else begin
            case (ph)
                PH_ONE: begin
                    raw[0]  = b64_char({r_prev[1:0], 4'd0});
                    raw[1]  = CHAR_PAD;
                    raw[2]  = CHAR_PAD;
                    raw_cnt = 2'd3;
                end
                PH_TWO: begin
                    raw[0]  = b64_char({r_prev[3:0], 2'd0});
                    raw[1]  = CHAR_PAD;
                    raw_cnt = 2'd2;
                end
                default: begin
                    raw_cnt = 2'd0;
                end
            endcase
        end

        // Place each character, followed by a newline when the line fills.
        o_grp = '0;
        col   = r_col;
        cnt   = 3'd0;
        for (int k = 0; k < RAW_MAX; k++) begin
            if (k < int'(raw_cnt)) begin
                if (cnt < 3'(MAX_RES)) begin
                    o_grp.chars[cnt[1:0]] = raw[k];
                    cnt = cnt + 3'd1;
                end
                col = col + 8'd1;
                if (col >= r_line_len) begin
                    if (cnt < 3'(MAX_RES)) begin
                        o_grp.chars[cnt[1:0]] = CHAR_NL;
                        cnt = cnt + 3'd1;
                    end
                    col = 8'd0;
                end
            end
        end
        o_grp.count = cnt;
        n_col = (r_cmd == CMD_FLUSH) ? 8'd0 : col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_ZERO;
            r_prev     <= 8'd0;
            r_col      <= 8'd0;
            r_line_len <= LINE_LENGTH_RST;
        end else begin
            if (i_cfg_we) begin
                r_line_len <= i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (n_take) begin
                r_in_valid <= 1'b0;
            end
            if (n_take) begin
                r_phase <= n_phase;
                r_col   <= n_col;
                r_prev  <= (r_cmd == CMD_FLUSH) ? 8'd0 : r_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd  <= i_in.command;
            r_byte <= i_in.data_byte;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/b64e_serial.sv
`default_nettype none
module b64e_serial
    import b64e_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_group i_grp,
    input  wire logic   i_grp_valid,
    output logic        o_grp_ready,
    b64e_out_if.source  o_out
);

    logic [MAX_RES-1:0][6:0] r_chars;
    logic [2:0]              r_cnt;
    logic [1:0]              r_idx;
    logic                    r_busy;

    logic n_adv;
    logic n_last;

    assign n_last      = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign n_adv       = r_busy && o_out.ready;
    assign o_grp_ready = !r_busy || (n_adv && n_last);

    assign o_out.valid    = r_busy;
    assign o_out.out_char = r_chars[r_idx];
    assign o_out.is_last  = n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
            r_cnt  <= 3'd0;
        end else if (i_grp_valid && o_grp_ready) begin
            // Load the next group; an empty group leaves nothing to send.
            r_busy <= (i_grp.count != 3'd0);
            r_cnt  <= i_grp.count;
            r_idx  <= 2'd0;
        end else if (n_adv) begin
            if (n_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_valid && o_grp_ready) begin
            r_chars <= i_grp.chars;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/base64_encoder_line_wrap.sv
// Streaming Base64 encoder (A-Z a-z 0-9 + /) with line wrapping.
// Input channel i_in: command (0 = data byte, 1 = end of input) and
// data_byte; a transaction completes when valid and ready are both high.
// Output channel o_out: one ASCII character per transaction in out_char,
// with is_last set on the final character caused by an input item.
// A data byte gives one or two alphabet characters; end of input flushes
// pending bits with '=' padding, then restarts phase and column.
// Each character taking the column to line_length or more gets a newline.
// i_cfg_we / i_cfg_wdata write line_length; write it only while idle.
// The first character of an item is presented from the character stage
// after the item has passed through the input register.
// The character stage sends one output character per cycle while
// o_out.ready is high; an item holds it until its characters (one to
// four) are all sent, and an end of input with no pending bits passes
// through it without sending any.
// The input register accepts a new item while the character stage still
// waits on a stalled receiver; once both are full, i_in.ready drops.
// Reset (i_rst_n, synchronous) clears phase, previous byte and column and
// sets line_length to 72.
`default_nettype none
module base64_encoder_line_wrap
    import b64e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    b64e_in_if.sink         i_in,
    b64e_out_if.source      o_out
);

    t_group grp;
    logic   grp_valid;
    logic   grp_ready;

    b64e_encode u_encode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_grp       (grp),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready)
    );

    b64e_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (grp),
        .i_grp_valid (grp_valid),
        .o_grp_ready (grp_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
